// ===== rtl/core/cobs_frame_decoder_unit_macros.svh =====
// assertion macros for the cobs frame decoder
// no dependencies; included by modules that carry assertions
`ifndef COBS_FRAME_DECODER_UNIT_MACROS_SVH
`define COBS_FRAME_DECODER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define CFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CFD_ASSERT(lbl, clk, rst, prop, msg)
`define CFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/cfd_pkg.sv =====
// types and constants shared by the cobs frame decoder modules
// no dependencies
package cfd_pkg;

   localparam logic [7:0] CODE_FULL = 8'hFF;
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_CODE = 2'd1,
      ST_TRUNCATED = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] enc_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [7:0] dec_byte;
      logic       byte_valid;
      logic       frame_done;
      logic [1:0] frame_status;
   } rsp_type;

   typedef struct packed {
      logic [7:0] enc_byte;
      logic       last;
      logic       is_zero;
      logic       is_full;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

// ===== rtl/core/cfd_front.sv =====
// front end: takes input transactions and classifies each byte
// depends on cfd_pkg
module cfd_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cfd_pkg::req_type          req_data,
   input  cfd_pkg::queue_status_type q_status,
   output logic                      push,
   output cfd_pkg::cmd_type          push_cmd
);
   import cfd_pkg::*;

   assign req_stall         = q_status.full;
   assign push              = req_valid && !q_status.full;
   assign push_cmd.enc_byte = req_data.enc_byte;
   assign push_cmd.last     = req_data.buffer_end;
   assign push_cmd.is_zero  = (req_data.enc_byte == BYTE_ZERO);
   assign push_cmd.is_full  = (req_data.enc_byte == CODE_FULL);

endmodule

// ===== rtl/core/cfd_queue.sv =====
// two-entry queue of classified bytes between front and back
// depends on cfd_pkg
module cfd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cfd_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output cfd_pkg::cmd_type          head_cmd,
   output cfd_pkg::queue_status_type q_status
);
   import cfd_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd           = entry_ff[rd_ptr_ff];
   assign q_status.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.not_empty = (count_ff != '0);

endmodule

// ===== rtl/core/cfd_back.sv =====
// back end: decoder state, result generation and output register
// depends on cfd_pkg and the assertion macro header
`include "cobs_frame_decoder_unit_macros.svh"
module cfd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  cfd_pkg::cmd_type          head_cmd,
   input  cfd_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cfd_pkg::rsp_type          rsp_data
);
   import cfd_pkg::*;

   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic        prev_full_ff, prev_full_in;
   logic        seen_code_ff, seen_code_in;
   status_type  error_ff, error_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [7:0]  dec;
   logic        valid;
   status_type  status;

   assign pop = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      bytes_left_in = bytes_left_ff;
      prev_full_in  = prev_full_ff;
      seen_code_in  = seen_code_ff;
      error_in      = error_ff;
      dec           = BYTE_ZERO;
      valid         = 1'b0;
      status        = ST_OK;
      priority if (error_ff != ST_OK) begin
         status = error_ff;
      end else if (head_cmd.last && head_cmd.is_zero) begin
         priority if (!seen_code_ff) status = ST_EMPTY;
         else if (bytes_left_ff != 8'd0) status = ST_TRUNCATED;
         else status = ST_OK;
      end else if (bytes_left_ff != 8'd0) begin
         dec           = head_cmd.enc_byte;
         valid         = 1'b1;
         bytes_left_in = bytes_left_ff - 8'd1;
         status        = (bytes_left_in != 8'd0) ? ST_TRUNCATED : ST_OK;
      end else begin
         if (seen_code_ff && !prev_full_ff) begin
            valid = 1'b1;
         end
         if (head_cmd.is_zero) begin
            error_in = ST_ZERO_CODE;
            status   = ST_ZERO_CODE;
         end else begin
            seen_code_in  = 1'b1;
            prev_full_in  = head_cmd.is_full;
            bytes_left_in = head_cmd.enc_byte - 8'd1;
            status        = (bytes_left_in != 8'd0) ? ST_TRUNCATED : ST_OK;
         end
      end
      if (head_cmd.last) begin
         bytes_left_in = 8'd0;
         prev_full_in  = 1'b0;
         seen_code_in  = 1'b0;
         error_in      = ST_OK;
      end

      rsp_in.dec_byte     = valid ? dec : BYTE_ZERO;
      rsp_in.byte_valid   = valid;
      rsp_in.frame_done   = head_cmd.last;
      rsp_in.frame_status = head_cmd.last ? status : ST_OK;

      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 8'd0;
         prev_full_ff  <= 1'b0;
         seen_code_ff  <= 1'b0;
         error_ff      <= ST_OK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            bytes_left_ff <= bytes_left_in;
            prev_full_ff  <= prev_full_in;
            seen_code_ff  <= seen_code_in;
            error_ff      <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CFD_ASSERT(a_err_code_pos, clock, reset, (error_ff == ST_OK) || (bytes_left_ff == 8'd0), "error with group open")
   `CFD_ASSERT_NEXT(a_frame_clear, clock, reset, pop && head_cmd.last, (bytes_left_ff == 8'd0) && !seen_code_ff && (error_ff == ST_OK), "state not cleared at frame end")
   `CFD_ASSERT(a_no_pop_empty, clock, reset, !pop || q_status.not_empty, "pop from empty queue")
   `CFD_ASSERT(a_status_done, clock, reset, !rsp_valid_ff || rsp_ff.frame_done || (rsp_ff.frame_status == ST_OK), "status without frame end")

endmodule

// ===== rtl/core/cobs_frame_decoder_unit.sv =====
// cobs frame decoder: one encoded byte in, one result out per transaction
// result path: an accepted byte is written into the queue, then decoded into the output register
// throughput: 1 transaction per cycle while rsp_stall is low
// reset: synchronous, active high; clears decoder state, queue and output valid
// depends on cfd_pkg, cfd_front, cfd_queue and cfd_back
module cobs_frame_decoder_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cfd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cfd_pkg::rsp_type rsp_data
);
   import cfd_pkg::*;

   queue_status_type q_status;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             push;
   logic             pop;

   cfd_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   cfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   cfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
